// ===== hdl/rec_pkg.sv =====
// Shared types and constants for the rotary encoder with click classifier.
// No dependencies; every other file in hdl/ refers to this package by scope.
package rec_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int TIME_W          = 32;
  localparam int CFG_W           = 16;
  localparam int CFG_ADDR_W      = 2;
  localparam int POS_W           = 16;
  localparam int IN_TDATA_W      = 40;
  localparam int OUT_TDATA_W     = 16;

  // input selector codes
  localparam logic [1:0] FUNC_A_EDGE   = 2'd0;
  localparam logic [1:0] FUNC_KEY_EDGE = 2'd1;
  localparam logic [1:0] FUNC_CHECK    = 2'd2;

  // decoded item kinds
  localparam logic [1:0] KIND_NOP      = 2'd0;
  localparam logic [1:0] KIND_A_EDGE   = 2'd1;
  localparam logic [1:0] KIND_KEY_EDGE = 2'd2;
  localparam logic [1:0] KIND_CHECK    = 2'd3;

  // key event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_LONG   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DOUBLE    = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd10;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd500;
  localparam logic [CFG_W-1:0] DOUBLE_RST   = 16'd300;

  typedef struct packed {
    logic [1:0]        kind;
    logic              a_level;
    logic              b_level;
    logic              key_pin;
    logic [TIME_W-1:0] time_ms;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/rec_front.sv =====
// Front stage: accepts input beats, decodes the selector into an item kind.
// Depends on rec_pkg; feeds rec_queue.
module rec_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rec_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [1:0]                       in_tuser,
  input  rec_pkg::q_stat_t                 q_stat,
  output logic                             push,
  output rec_pkg::item_t                   push_item
);

  logic           front_valid_r;
  logic           front_valid_nxt;
  rec_pkg::item_t front_item_r;
  rec_pkg::item_t front_item_nxt;
  logic           accept;

  assign push      = front_valid_r && !q_stat.full;
  assign in_tready = !front_valid_r || !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign push_item = front_item_r;

  always_comb begin
    front_item_nxt           = front_item_r;
    front_item_nxt.a_level   = in_tdata[0];
    front_item_nxt.b_level   = in_tdata[1];
    front_item_nxt.key_pin   = in_tdata[2];
    front_item_nxt.time_ms   = in_tdata[3 +: rec_pkg::TIME_W];
    unique case (in_tuser)
      rec_pkg::FUNC_A_EDGE:   front_item_nxt.kind = rec_pkg::KIND_A_EDGE;
      rec_pkg::FUNC_KEY_EDGE: front_item_nxt.kind = rec_pkg::KIND_KEY_EDGE;
      rec_pkg::FUNC_CHECK:    front_item_nxt.kind = rec_pkg::KIND_CHECK;
      default:                front_item_nxt.kind = rec_pkg::KIND_NOP;
    endcase
  end

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (accept) begin
      front_valid_nxt = 1'b1;
    end else if (push) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_item_r <= front_item_nxt;
    end
  end

endmodule

// ===== hdl/rec_queue.sv =====
// Short queue of decoded items between the front and back stages.
// Depends on rec_pkg for the item type and depth.
module rec_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rec_pkg::item_t   push_item,
  input  logic             pop,
  output rec_pkg::item_t   pop_item,
  output rec_pkg::q_stat_t q_stat
);

  localparam int PTR_W = $clog2(rec_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(rec_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rec_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(rec_pkg::QUEUE_DEPTH);

  rec_pkg::item_t   mem [rec_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);
  assign pop_item     = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/rec_back.sv =====
// Back stage: quadrature count, key debounce and click classification,
// configuration registers and the output register. Depends on rec_pkg.
module rec_back #(
  parameter int COUNT_WIDTH = rec_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rec_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rec_pkg::CFG_W-1:0]        cfg_wdata,
  input  rec_pkg::q_stat_t                 q_stat,
  input  rec_pkg::item_t                   pop_item,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rec_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [2:0]                       out_tuser
);

  localparam int TW = rec_pkg::TIME_W;

  logic [rec_pkg::CFG_W-1:0] debounce_r;
  logic [rec_pkg::CFG_W-1:0] long_limit_r;
  logic [rec_pkg::CFG_W-1:0] double_win_r;

  logic                   a_armed_r,    a_armed_nxt;
  logic                   b_at_fall_r,  b_at_fall_nxt;
  logic [COUNT_WIDTH-1:0] detent_r,     detent_nxt;
  logic [TW-1:0]          last_key_r,   last_key_nxt;
  logic                   key_down_r,   key_down_nxt;
  logic [TW-1:0]          press_start_r, press_start_nxt;
  logic [1:0]             clicks_r,     clicks_nxt;
  logic [TW-1:0]          first_click_r, first_click_nxt;
  logic [1:0]             ev_nxt;
  logic [1:0]             clicks_inc;

  logic [TW-1:0] dt_last;
  logic [TW-1:0] dt_press;
  logic [TW-1:0] dt_first;

  logic                         out_valid_r;
  logic [rec_pkg::POS_W-1:0]    position_r;
  logic [1:0]                   ev_r;

  assign pop        = !q_stat.empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = position_r;
  assign out_tuser  = {ev_r, ev_r != rec_pkg::EV_NONE};

  assign dt_last    = pop_item.time_ms - last_key_r;
  assign dt_press   = pop_item.time_ms - press_start_r;
  assign dt_first   = pop_item.time_ms - first_click_r;
  assign clicks_inc = clicks_r + 2'd1;

  always_comb begin
    a_armed_nxt     = a_armed_r;
    b_at_fall_nxt   = b_at_fall_r;
    detent_nxt      = detent_r;
    last_key_nxt    = last_key_r;
    key_down_nxt    = key_down_r;
    press_start_nxt = press_start_r;
    clicks_nxt      = clicks_r;
    first_click_nxt = first_click_r;
    ev_nxt          = rec_pkg::EV_NONE;
    unique case (pop_item.kind)
      rec_pkg::KIND_A_EDGE: begin
        if (!pop_item.a_level && !a_armed_r) begin
          a_armed_nxt   = 1'b1;
          b_at_fall_nxt = pop_item.b_level;
        end else if (pop_item.a_level && a_armed_r) begin
          a_armed_nxt = 1'b0;
          if (b_at_fall_r && !pop_item.b_level) begin
            detent_nxt = detent_r + COUNT_WIDTH'(1);
          end else if (!b_at_fall_r && pop_item.b_level) begin
            detent_nxt = detent_r - COUNT_WIDTH'(1);
          end
        end
      end
      rec_pkg::KIND_KEY_EDGE: begin
        if (dt_last >= TW'(debounce_r)) begin
          last_key_nxt = pop_item.time_ms;
          if (!pop_item.key_pin && !key_down_r) begin
            key_down_nxt    = 1'b1;
            press_start_nxt = pop_item.time_ms;
          end else if (pop_item.key_pin && key_down_r) begin
            key_down_nxt = 1'b0;
            if (dt_press >= TW'(long_limit_r)) begin
              ev_nxt     = rec_pkg::EV_LONG;
              clicks_nxt = 2'd0;
            end else begin
              clicks_nxt = clicks_inc;
              if (clicks_inc == 2'd1) begin
                first_click_nxt = pop_item.time_ms;
              end else if (clicks_inc == 2'd2) begin
                ev_nxt     = (dt_first < TW'(double_win_r)) ? rec_pkg::EV_DOUBLE
                                                           : rec_pkg::EV_SINGLE;
                clicks_nxt = 2'd0;
              end
            end
          end
        end
      end
      rec_pkg::KIND_CHECK: begin
        if (clicks_r == 2'd1 && dt_first > TW'(double_win_r)) begin
          ev_nxt     = rec_pkg::EV_SINGLE;
          clicks_nxt = 2'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= rec_pkg::DEBOUNCE_RST;
      long_limit_r <= rec_pkg::LONG_RST;
      double_win_r <= rec_pkg::DOUBLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rec_pkg::REG_DEBOUNCE: debounce_r   <= cfg_wdata;
        rec_pkg::REG_LONG:     long_limit_r <= cfg_wdata;
        rec_pkg::REG_DOUBLE:   double_win_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_armed_r     <= 1'b0;
      b_at_fall_r   <= 1'b0;
      detent_r      <= '0;
      last_key_r    <= '0;
      key_down_r    <= 1'b0;
      press_start_r <= '0;
      clicks_r      <= 2'd0;
      first_click_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (pop) begin
        a_armed_r     <= a_armed_nxt;
        b_at_fall_r   <= b_at_fall_nxt;
        detent_r      <= detent_nxt;
        last_key_r    <= last_key_nxt;
        key_down_r    <= key_down_nxt;
        press_start_r <= press_start_nxt;
        clicks_r      <= clicks_nxt;
        first_click_r <= first_click_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      position_r <= rec_pkg::POS_W'(detent_nxt);
      ev_r       <= ev_nxt;
    end
  end

endmodule

// ===== hdl/rotary_encoder_with_click_classifier.sv =====
// Rotary encoder with click classifier, top level: front, queue and back.
// Path: a beat is held in the front register, written into a queue entry and
// then captured in the back stage's output register that drives out_tvalid.
// Throughput: one beat per cycle while the output is not stalled; the four-entry
// queue and output register absorb stalls. Synchronous active-low rst_n clears
// valid flags, decoder state, queue pointers; cfg regs load 10, 500 and 300 ms.
module rotary_encoder_with_click_classifier #(
  parameter int COUNT_WIDTH = rec_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rec_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rec_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // a_level, b_level, key_pin, time_ms[31:0], zero pad
  input  logic [rec_pkg::IN_TDATA_W-1:0]   in_tdata,
  // func[1:0]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // position[15:0]
  output logic [rec_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // event_valid, event_kind[1:0]
  output logic [2:0]                       out_tuser
);

  rec_pkg::q_stat_t q_stat;
  rec_pkg::item_t   push_item;
  rec_pkg::item_t   pop_item;
  logic             push;
  logic             pop;

  rec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  rec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  rec_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_stat     (q_stat),
    .pop_item   (pop_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_flag_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tuser[2:1] != rec_pkg::EV_NONE)))
    else $error("event flag and event kind disagree");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_stat.full)
    else $error("input stalled with room in queue");

endmodule
